[rtl/ga3s_pkg.sv]
// Shared types, constants and sizing helpers for the 3D adjoint gradient stencil.
package ga3s_pkg;

    localparam int SX_W  = 7;
    localparam int SY_W  = 7;
    localparam int SZ_W  = 13;
    localparam int V_W   = 32;
    localparam int D_W   = V_W + 1;
    localparam int P_W   = 2 * V_W + 1;
    localparam int FRAC  = 16;
    localparam int REG_W = 32;
    localparam int IDX_W = 3;

    // largest row/plane count a 7-bit size register can hold, and largest plane count a 13-bit one can hold
    localparam int ROW_CAP   = 2 ** SX_W - 1;
    localparam int DEPTH_CAP = 2 ** SZ_W - 1;

    localparam logic [SX_W-1:0]         SIZE_RST  = SX_W'(64);
    localparam logic [SZ_W-1:0]         DEPTH_RST = SZ_W'(64);
    localparam logic signed [V_W-1:0]   COEF_RST  = 32'shFFFF_0000;
    localparam logic signed [V_W-1:0]   SAT_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [V_W-1:0]   SAT_MIN   = 32'sh8000_0000;

    localparam logic KIND_VOXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef enum logic [IDX_W-1:0] {
        REG_SIZE_X = 3'd0,
        REG_SIZE_Y = 3'd1,
        REG_SIZE_Z = 3'd2,
        REG_COEF_X = 3'd3,
        REG_COEF_Y = 3'd4,
        REG_COEF_Z = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic                  kind;
        logic signed [V_W-1:0] comp_x;
        logic signed [V_W-1:0] comp_y;
        logic signed [V_W-1:0] comp_z;
    } t_in;

    typedef struct packed {
        logic signed [V_W-1:0] result_value;
        logic                  volume_end;
    } t_out;

    // control that rides alongside the ring read data
    typedef struct packed {
        logic                  valid;
        logic                  first_x;
        logic                  first_y;
        logic                  first_z;
        logic                  vol_end;
        logic signed [V_W-1:0] z_next;
    } t_tap;

    typedef struct packed {
        logic valid;
        logic vol_end;
    } t_ctl;

    function automatic int plane_cap(input int max_plane);
        return (max_plane < ROW_CAP * ROW_CAP) ? max_plane : ROW_CAP * ROW_CAP;
    endfunction

    function automatic int pos_width(input int max_plane, input int max_depth);
        longint t;
        t = longint'(plane_cap(max_plane))
            * longint'((max_depth < DEPTH_CAP) ? max_depth : DEPTH_CAP) + 64'sd1;
        return $clog2(t);
    endfunction

endpackage

[rtl/grad_adjoint_3d_stencil_top.sv]
// Top level of the streaming 3D adjoint gradient (divergence) stencil.
//
// Voxels enter in raster order (x fastest, then y, then z) as items carrying
// the x, y and z gradient components in signed Q16.16; each result item is
// coef_x*dx + coef_y*dy + coef_z*dz for one voxel, with backward differences
// except at index 0 of an axis, where the difference is forward. The result
// for voxel w comes from the item carrying voxel w plus one plane, so the
// first plane gives no results; once a whole volume is in, drain items
// (kind 1) flush the last plane one result each, and volume_end marks the
// final voxel, after which a new volume may start. Voxels beyond the volume
// and drain items arriving before the volume is complete are swallowed without a result.
// Throughput is one item per clock, sustained while o_stall stays low. A
// result item is presented after the ring read and the neighbour control
// are registered on the edge that takes its item; then come a difference
// stage, a multiply stage and an adder stage, with the final add landing in
// the output register. A held result freezes the whole pipe and raises
// o_stall until it is taken.
// The ring is two synchronous memories of 2**AW entries (8192 with default
// parameters), both written with each voxel, each read at two addresses per
// cycle: the voxel itself, its x and y neighbours and the voxel one plane
// back; the voxel one plane ahead is the item arriving that cycle. The ring
// needs no clearing pass, since only voxels already received are read.
// Writing a size register restarts the volume and holds o_stall high while
// the clamped sizes and plane/volume products settle; the same holds after
// reset. Coefficient writes take effect at once. Configure only while no
// item is in flight.
module grad_adjoint_3d_stencil_top import ga3s_pkg::*; #(
    parameter int MAX_ROW   = 64,
    parameter int MAX_PLANE = 4096,
    parameter int MAX_DEPTH = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_idx,
    input  logic [REG_W-1:0]   i_cfg_data,
    // voxel / drain items in
    input  logic               i_valid,
    output logic               o_stall,
    input  t_in                i_item,
    // result items out
    output logic               o_valid,
    input  logic               i_stall,
    output t_out               o_item
);

    localparam int PL_W  = $clog2(plane_cap(MAX_PLANE) + 1);
    localparam int POS_W = pos_width(MAX_PLANE, MAX_DEPTH);
    localparam int AW    = $clog2(2 * plane_cap(MAX_PLANE));

    logic                  size_wr, cfg_busy;
    logic [SX_W-1:0]       nx, nx_m1;
    logic [SY_W-1:0]       ny_m1;
    logic [PL_W-1:0]       plane;
    logic [POS_W-1:0]      total, total_m1;
    logic signed [V_W-1:0] coef_x, coef_y, coef_z;

    logic                  pipe_en, accept;
    logic                  we;
    logic [AW-1:0]         waddr, addr_e, addr_x, addr_y, addr_z;
    t_tap                  tap;
    logic [V_W-1:0]        own_x, own_y, own_z, nb_x, nb_y, nb_z;

    // whole pipeline advances unless a finished item is held at the output
    assign pipe_en = !(o_valid && i_stall);
    assign o_stall = !pipe_en || cfg_busy;
    assign accept  = i_valid && !o_stall;

    ga3s_cfg #(
        .MAX_ROW   (MAX_ROW),
        .MAX_PLANE (MAX_PLANE),
        .MAX_DEPTH (MAX_DEPTH),
        .PL_W      (PL_W),
        .POS_W     (POS_W)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_size_wr  (size_wr),
        .o_busy     (cfg_busy),
        .o_nx       (nx),
        .o_nx_m1    (nx_m1),
        .o_ny_m1    (ny_m1),
        .o_plane    (plane),
        .o_total    (total),
        .o_total_m1 (total_m1),
        .o_coef_x   (coef_x),
        .o_coef_y   (coef_y),
        .o_coef_z   (coef_z)
    );

    // positions in the volume, ring write slot and neighbour read slots
    ga3s_seq #(
        .AW    (AW),
        .PL_W  (PL_W),
        .POS_W (POS_W)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (pipe_en),
        .i_accept   (accept),
        .i_item     (i_item),
        .i_size_wr  (size_wr),
        .i_nx       (nx),
        .i_nx_m1    (nx_m1),
        .i_ny_m1    (ny_m1),
        .i_plane    (plane),
        .i_total    (total),
        .i_total_m1 (total_m1),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_addr_e   (addr_e),
        .o_addr_x   (addr_x),
        .o_addr_y   (addr_y),
        .o_addr_z   (addr_z),
        .o_tap      (tap)
    );

    ga3s_ring #(
        .AW (AW)
    ) u_ring (
        .i_clk    (i_clk),
        .i_en     (pipe_en),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  ({i_item.comp_x, i_item.comp_y, i_item.comp_z}),
        .i_addr_e (addr_e),
        .i_addr_x (addr_x),
        .i_addr_y (addr_y),
        .i_addr_z (addr_z),
        .o_own_x  (own_x),
        .o_own_y  (own_y),
        .o_own_z  (own_z),
        .o_nb_x   (nb_x),
        .o_nb_y   (nb_y),
        .o_nb_z   (nb_z)
    );

    ga3s_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_tap    (tap),
        .i_own_x  (own_x),
        .i_own_y  (own_y),
        .i_own_z  (own_z),
        .i_nb_x   (nb_x),
        .i_nb_y   (nb_y),
        .i_nb_z   (nb_z),
        .i_coef_x (coef_x),
        .i_coef_y (coef_y),
        .i_coef_z (coef_z),
        .o_valid  (o_valid),
        .o_item   (o_item)
    );

endmodule

[rtl/ga3s_cfg.sv]
// Configuration registers, size clamping and derived plane/volume counts.
module ga3s_cfg import ga3s_pkg::*; #(
    parameter int MAX_ROW   = 64,
    parameter int MAX_PLANE = 4096,
    parameter int MAX_DEPTH = 4096,
    parameter int PL_W      = 13,
    parameter int POS_W     = 25
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [IDX_W-1:0]       i_cfg_idx,
    input  logic [REG_W-1:0]       i_cfg_data,
    output logic                   o_size_wr,
    output logic                   o_busy,
    output logic [SX_W-1:0]        o_nx,
    output logic [SX_W-1:0]        o_nx_m1,
    output logic [SY_W-1:0]        o_ny_m1,
    output logic [PL_W-1:0]        o_plane,
    output logic [POS_W-1:0]       o_total,
    output logic [POS_W-1:0]       o_total_m1,
    output logic signed [V_W-1:0]  o_coef_x,
    output logic signed [V_W-1:0]  o_coef_y,
    output logic signed [V_W-1:0]  o_coef_z
);

    localparam int XHI_I = (MAX_ROW < MAX_PLANE / 2) ? MAX_ROW : MAX_PLANE / 2;
    localparam logic [SX_W-1:0] XHI = SX_W'((XHI_I > ROW_CAP) ? ROW_CAP : XHI_I);
    localparam logic [SZ_W-1:0] ZHI = SZ_W'((MAX_DEPTH > DEPTH_CAP) ? DEPTH_CAP : MAX_DEPTH);
    localparam logic [1:0]      SETTLE = 2'd3;

    logic [SX_W-1:0]       r_size_x;
    logic [SY_W-1:0]       r_size_y;
    logic [SZ_W-1:0]       r_size_z;
    logic signed [V_W-1:0] r_coef_x, r_coef_y, r_coef_z;
    logic [1:0]            r_settle;

    logic [SX_W-1:0]       r_nx, r_nx_m1, nx_c;
    logic [SY_W-1:0]       r_ny, r_ny_m1, ny_c, yhi;
    logic [SZ_W-1:0]       r_nz, nz_c;
    logic [PL_W-1:0]       r_plane;
    logic [POS_W-1:0]      r_total, r_total_m1;
    logic [2*SX_W-1:0]     plane_full;
    logic [PL_W+SZ_W-1:0]  total_full, total_m1_full;

    // upper bound on rows per plane for each row length, fixed at elaboration
    logic [SY_W-1:0] c_yhi [0:ROW_CAP];
    for (genvar g = 0; g <= ROW_CAP; g++) begin : g_yhi
        localparam int YQ = MAX_PLANE / ((g < 2) ? 2 : g);
        assign c_yhi[g] = SY_W'((YQ > ROW_CAP) ? ROW_CAP : YQ);
    end

    assign o_size_wr = i_cfg_we && (i_cfg_idx == REG_SIZE_X || i_cfg_idx == REG_SIZE_Y
                                    || i_cfg_idx == REG_SIZE_Z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_RST;
            r_size_y <= SIZE_RST;
            r_size_z <= DEPTH_RST;
            r_coef_x <= COEF_RST;
            r_coef_y <= COEF_RST;
            r_coef_z <= COEF_RST;
            r_settle <= SETTLE;
        end else begin
            if (o_size_wr) begin
                r_settle <= SETTLE;
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SIZE_X: r_size_x <= i_cfg_data[SX_W-1:0];
                    REG_SIZE_Y: r_size_y <= i_cfg_data[SY_W-1:0];
                    REG_SIZE_Z: r_size_z <= i_cfg_data[SZ_W-1:0];
                    REG_COEF_X: r_coef_x <= i_cfg_data[V_W-1:0];
                    REG_COEF_Y: r_coef_y <= i_cfg_data[V_W-1:0];
                    REG_COEF_Z: r_coef_z <= i_cfg_data[V_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        if (r_size_x < SX_W'(2)) begin
            nx_c = SX_W'(2);
        end else if (r_size_x > XHI) begin
            nx_c = XHI;
        end else begin
            nx_c = r_size_x;
        end
        yhi = c_yhi[nx_c];
        if (r_size_y < SY_W'(2)) begin
            ny_c = SY_W'(2);
        end else if (r_size_y > yhi) begin
            ny_c = yhi;
        end else begin
            ny_c = r_size_y;
        end
        if (r_size_z < SZ_W'(2)) begin
            nz_c = SZ_W'(2);
        end else if (r_size_z > ZHI) begin
            nz_c = ZHI;
        end else begin
            nz_c = r_size_z;
        end
    end

    assign plane_full    = r_nx * r_ny;
    assign total_full    = r_plane * r_nz;
    assign total_m1_full = total_full - (PL_W+SZ_W)'(1);

    // clamp -> plane product -> volume product, one register each
    always_ff @(posedge i_clk) begin
        r_nx       <= nx_c;
        r_ny       <= ny_c;
        r_nz       <= nz_c;
        r_nx_m1    <= nx_c - SX_W'(1);
        r_ny_m1    <= ny_c - SY_W'(1);
        r_plane    <= plane_full[PL_W-1:0];
        r_total    <= total_full[POS_W-1:0];
        r_total_m1 <= total_m1_full[POS_W-1:0];
    end

    assign o_busy     = (r_settle != 2'd0);
    assign o_nx       = r_nx;
    assign o_nx_m1    = r_nx_m1;
    assign o_ny_m1    = r_ny_m1;
    assign o_plane    = r_plane;
    assign o_total    = r_total;
    assign o_total_m1 = r_total_m1;
    assign o_coef_x   = r_coef_x;
    assign o_coef_y   = r_coef_y;
    assign o_coef_z   = r_coef_z;

endmodule

[rtl/ga3s_seq.sv]
// Volume position tracking and ring addressing for each accepted item.
module ga3s_seq import ga3s_pkg::*; #(
    parameter int AW    = 13,
    parameter int PL_W  = 13,
    parameter int POS_W = 25
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_accept,
    input  t_in                i_item,
    input  logic               i_size_wr,
    input  logic [SX_W-1:0]    i_nx,
    input  logic [SX_W-1:0]    i_nx_m1,
    input  logic [SY_W-1:0]    i_ny_m1,
    input  logic [PL_W-1:0]    i_plane,
    input  logic [POS_W-1:0]   i_total,
    input  logic [POS_W-1:0]   i_total_m1,
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output logic [AW-1:0]      o_addr_e,
    output logic [AW-1:0]      o_addr_x,
    output logic [AW-1:0]      o_addr_y,
    output logic [AW-1:0]      o_addr_z,
    output t_tap               o_tap
);

    logic [POS_W-1:0] r_w, n_w, r_e, n_e;
    logic [SX_W-1:0]  r_i, n_i;
    logic [SY_W-1:0]  r_j, n_j;
    logic             r_k0, n_k0;
    t_tap             r_tap, n_tap;

    logic store, emit_v, emit_d, emit, last;
    logic [AW-1:0] ea, nx_a, pl_a;

    assign store  = i_accept && (i_item.kind == KIND_VOXEL) && (r_w < i_total);
    assign emit_v = store && (r_w >= POS_W'(i_plane));
    assign emit_d = i_accept && (i_item.kind == KIND_DRAIN) && (r_w == i_total)
                    && (r_e < i_total);
    assign emit   = emit_v || emit_d;
    assign last   = emit_d && (r_e == i_total_m1);

    always_comb begin
        n_w  = r_w;
        n_e  = r_e;
        n_i  = r_i;
        n_j  = r_j;
        n_k0 = r_k0;
        if (i_size_wr || last) begin
            n_w  = '0;
            n_e  = '0;
            n_i  = '0;
            n_j  = '0;
            n_k0 = 1'b1;
        end else begin
            if (store) begin
                n_w = r_w + POS_W'(1);
            end
            if (emit) begin
                n_e = r_e + POS_W'(1);
                if (r_i == i_nx_m1) begin
                    n_i = '0;
                    if (r_j == i_ny_m1) begin
                        n_j  = '0;
                        n_k0 = 1'b0;
                    end else begin
                        n_j = r_j + SY_W'(1);
                    end
                end else begin
                    n_i = r_i + SX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w  <= '0;
            r_e  <= '0;
            r_i  <= '0;
            r_j  <= '0;
            r_k0 <= 1'b1;
        end else begin
            r_w  <= n_w;
            r_e  <= n_e;
            r_i  <= n_i;
            r_j  <= n_j;
            r_k0 <= n_k0;
        end
    end

    // ring slot = low bits of the voxel position; window spans under two planes
    assign ea   = r_e[AW-1:0];
    assign nx_a = AW'(i_nx);
    assign pl_a = AW'(i_plane);

    assign o_we     = store;
    assign o_waddr  = r_w[AW-1:0];
    assign o_addr_e = ea;
    assign o_addr_x = (r_i == '0) ? ea + AW'(1) : ea - AW'(1);
    assign o_addr_y = (r_j == '0) ? ea + nx_a : ea - nx_a;
    assign o_addr_z = ea - pl_a;

    always_comb begin
        n_tap.valid   = emit;
        n_tap.first_x = (r_i == '0);
        n_tap.first_y = (r_j == '0);
        n_tap.first_z = r_k0;
        n_tap.vol_end = last;
        n_tap.z_next  = i_item.comp_z;   // forward z neighbour is the item arriving now
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= '0;
        end else if (i_en) begin
            r_tap <= n_tap;
        end
    end

    assign o_tap = r_tap;

endmodule

[rtl/ga3s_ring.sv]
// Two-plane sample ring: a full-width copy and an x/y copy, each with two read ports.
module ga3s_ring import ga3s_pkg::*; #(
    parameter int AW = 13
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [3*V_W-1:0]   i_wdata,
    input  logic [AW-1:0]      i_addr_e,
    input  logic [AW-1:0]      i_addr_x,
    input  logic [AW-1:0]      i_addr_y,
    input  logic [AW-1:0]      i_addr_z,
    output logic [V_W-1:0]     o_own_x,
    output logic [V_W-1:0]     o_own_y,
    output logic [V_W-1:0]     o_own_z,
    output logic [V_W-1:0]     o_nb_x,
    output logic [V_W-1:0]     o_nb_y,
    output logic [V_W-1:0]     o_nb_z
);

    localparam int DEPTH = 2 ** AW;

    logic [3*V_W-1:0] r_mem_a [0:DEPTH-1];
    logic [2*V_W-1:0] r_mem_b [0:DEPTH-1];
    logic [3*V_W-1:0] r_rd_own, r_rd_z;
    logic [2*V_W-1:0] r_rd_x, r_rd_y;

    // read-before-write: a z neighbour sharing the slot being written sees old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_a[i_waddr] <= i_wdata;
            r_mem_b[i_waddr] <= i_wdata[3*V_W-1:V_W];
        end
        if (i_en) begin
            r_rd_own <= r_mem_a[i_addr_e];
            r_rd_z   <= r_mem_a[i_addr_z];
            r_rd_x   <= r_mem_b[i_addr_x];
            r_rd_y   <= r_mem_b[i_addr_y];
        end
    end

    assign o_own_x = r_rd_own[3*V_W-1:2*V_W];
    assign o_own_y = r_rd_own[2*V_W-1:V_W];
    assign o_own_z = r_rd_own[V_W-1:0];
    assign o_nb_z  = r_rd_z[V_W-1:0];
    assign o_nb_x  = r_rd_x[2*V_W-1:V_W];
    assign o_nb_y  = r_rd_y[V_W-1:0];

endmodule

[rtl/ga3s_arith.sv]
// Difference, weighting, exact sum, Q16.16 truncation and saturation pipeline.
module ga3s_arith import ga3s_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_tap                  i_tap,
    input  logic [V_W-1:0]        i_own_x,
    input  logic [V_W-1:0]        i_own_y,
    input  logic [V_W-1:0]        i_own_z,
    input  logic [V_W-1:0]        i_nb_x,
    input  logic [V_W-1:0]        i_nb_y,
    input  logic [V_W-1:0]        i_nb_z,
    input  logic signed [V_W-1:0] i_coef_x,
    input  logic signed [V_W-1:0] i_coef_y,
    input  logic signed [V_W-1:0] i_coef_z,
    output logic                  o_valid,
    output t_out                  o_item
);

    localparam int S_W = P_W + 2;
    localparam int Q_W = S_W - FRAC;

    logic signed [D_W-1:0] own_x, own_y, own_z, nb_x, nb_y, nb_z, zn;
    logic signed [D_W-1:0] dx, dy, dz, r_dx, r_dy, r_dz;
    logic signed [P_W-1:0] px, py, pz, r_px, r_py, r_pz, r_pz4;
    logic signed [P_W:0]   s01, r_s01;
    logic signed [S_W-1:0] sum;
    logic [Q_W-1:0]        sh;
    logic                  fits;
    logic signed [V_W-1:0] res;
    t_ctl                  r_c2, r_c3, r_c4;
    logic                  r_out_valid;
    t_out                  r_out_item;

    assign own_x = {i_own_x[V_W-1], i_own_x};
    assign own_y = {i_own_y[V_W-1], i_own_y};
    assign own_z = {i_own_z[V_W-1], i_own_z};
    assign nb_x  = {i_nb_x[V_W-1], i_nb_x};
    assign nb_y  = {i_nb_y[V_W-1], i_nb_y};
    assign nb_z  = {i_nb_z[V_W-1], i_nb_z};
    assign zn    = {i_tap.z_next[V_W-1], i_tap.z_next};

    // forward difference on the first index of an axis, backward elsewhere
    assign dx = i_tap.first_x ? nb_x - own_x : own_x - nb_x;
    assign dy = i_tap.first_y ? nb_y - own_y : own_y - nb_y;
    assign dz = i_tap.first_z ? zn - own_z : own_z - nb_z;

    assign px  = i_coef_x * r_dx;
    assign py  = i_coef_y * r_dy;
    assign pz  = i_coef_z * r_dz;
    assign s01 = r_px + r_py;
    assign sum = r_s01 + r_pz4;

    // dropping the low fraction bits floors the exact Q32.32 sum
    assign sh   = sum[S_W-1:FRAC];
    assign fits = (&sh[Q_W-1:V_W-1]) || !(|sh[Q_W-1:V_W-1]);
    assign res  = fits ? sh[V_W-1:0] : (sh[Q_W-1] ? SAT_MIN : SAT_MAX);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx       <= dx;
            r_dy       <= dy;
            r_dz       <= dz;
            r_px       <= px;
            r_py       <= py;
            r_pz       <= pz;
            r_s01      <= s01;
            r_pz4      <= r_pz;
            r_out_item.result_value <= res;
            r_out_item.volume_end   <= r_c4.vol_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2        <= '0;
            r_c3        <= '0;
            r_c4        <= '0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_c2.valid   <= i_tap.valid;
            r_c2.vol_end <= i_tap.vol_end;
            r_c3         <= r_c2;
            r_c4         <= r_c3;
            r_out_valid  <= r_c4.valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

endmodule
